/* design/pmss_pkg.sv */
// ----------------------------------------------------------------------------
// pmss_pkg: shared definitions of the polling slot scheduler
// Field widths, state, event and error codes, register indexes and the
// structs passed between the scheduler modules.
// ----------------------------------------------------------------------------
package pmss_pkg;

   localparam int SLOTS_DEFAULT = 8;

   localparam int KIND_W     = 3;
   localparam int SLOT_W     = 3;
   localparam int STATE_W    = 2;
   localparam int ERR_W      = 2;
   localparam int COUNT_W    = 4;
   localparam int MASK_W     = 8;
   localparam int TICK_W     = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [STATE_W-1:0] ST_SELECT   = 2'd0;
   localparam logic [STATE_W-1:0] ST_TRANSMIT = 2'd1;
   localparam logic [STATE_W-1:0] ST_RECEIVE  = 2'd2;
   localparam logic [STATE_W-1:0] ST_PAUSE    = 2'd3;

   localparam logic [ERR_W-1:0] ERR_NONE    = 2'd0;
   localparam logic [ERR_W-1:0] ERR_CRC     = 2'd1;
   localparam logic [ERR_W-1:0] ERR_TIMEOUT = 2'd2;

   localparam logic [KIND_W-1:0] KIND_RESPONSE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TX_DONE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TIMER    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_POLL     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_ACTIVATE = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_MASK    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RECEIVE_MASK  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_MASK   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PAUSE_TICKS   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 3'd5;

   typedef struct packed {
      logic [COUNT_W-1:0] slot_count;
      logic [MASK_W-1:0]  start_mask;
      logic [MASK_W-1:0]  receive_mask;
      logic [MASK_W-1:0]  repeat_mask;
      logic [TICK_W-1:0]  pause_ticks;
      logic [TICK_W-1:0]  timeout_ticks;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              crc_bad;
      logic [SLOT_W-1:0] slot_index;
   } event_type;

   typedef struct packed {
      logic [STATE_W-1:0] status;
      logic [SLOT_W-1:0]  current_slot;
      logic [SLOT_W-1:0]  last_error_slot;
      logic [ERR_W-1:0]   last_error_code;
      logic               call_on_start;
      logic               call_to_receive;
      logic               call_on_finish;
      logic               timer_load_now;
      logic [TICK_W-1:0]  timer_value;
      logic               slot_crc_error;
      logic               slot_timeout_error;
   } result_type;

endpackage

/* design/pmss_csr.sv */
// ----------------------------------------------------------------------------
// pmss_csr: configuration registers
// Write-only register file for slot count, per-slot masks and timer loads.
// ----------------------------------------------------------------------------
module pmss_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [pmss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pmss_pkg::CSR_DATA_W-1:0] csr_write_data,
   output pmss_pkg::cfg_type          cfg
);
   import pmss_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SLOT_COUNT:    cfg_in.slot_count    = csr_write_data[COUNT_W-1:0];
            CSR_START_MASK:    cfg_in.start_mask    = csr_write_data[MASK_W-1:0];
            CSR_RECEIVE_MASK:  cfg_in.receive_mask  = csr_write_data[MASK_W-1:0];
            CSR_REPEAT_MASK:   cfg_in.repeat_mask   = csr_write_data[MASK_W-1:0];
            CSR_PAUSE_TICKS:   cfg_in.pause_ticks   = csr_write_data[TICK_W-1:0];
            CSR_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_write_data[TICK_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/pmss_engine.sv */
// ----------------------------------------------------------------------------
// pmss_engine: scheduler state and event step
// Holds master state, current slot, per-slot flags and the error record;
// computes the result of one event and commits the new state on step.
// ----------------------------------------------------------------------------
module pmss_engine #(
   parameter int SLOTS = pmss_pkg::SLOTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  pmss_pkg::event_type  evt,
   input  pmss_pkg::cfg_type    cfg,
   output pmss_pkg::result_type res
);
   import pmss_pkg::*;

   localparam int FLAG_W = (SLOTS < MASK_W) ? SLOTS : MASK_W;

   logic [STATE_W-1:0] state_ff, state_in;
   logic [SLOT_W-1:0]  act_ff, act_in;
   logic [FLAG_W-1:0]  skip_ff, crc_ff, tmo_ff;
   logic [SLOT_W-1:0]  eslot_ff, eslot_in;
   logic [ERR_W-1:0]   ecode_ff, ecode_in;

   logic [MASK_W-1:0]  skip_ext, crc_ext, tmo_ext;
   logic [MASK_W-1:0]  skip_nxt, crc_nxt, tmo_nxt;
   logic [MASK_W-1:0]  cur_bit;
   logic [COUNT_W-1:0] list_len;
   logic               on_start, to_recv, on_finish, tload, found;
   logic [TICK_W-1:0]  tval;

   for (genvar g = 0; g < MASK_W; g++) begin : g_ext
      if (g < FLAG_W) begin : g_bit
         assign skip_ext[g] = skip_ff[g];
         assign crc_ext[g]  = crc_ff[g];
         assign tmo_ext[g]  = tmo_ff[g];
      end else begin : g_zero
         assign skip_ext[g] = 1'b0;
         assign crc_ext[g]  = 1'b0;
         assign tmo_ext[g]  = 1'b0;
      end
   end

   assign cur_bit  = MASK_W'(1) << act_ff;
   assign list_len = (cfg.slot_count > COUNT_W'(FLAG_W)) ? COUNT_W'(FLAG_W) : cfg.slot_count;

   always_comb begin
      state_in  = state_ff;
      act_in    = act_ff;
      eslot_in  = eslot_ff;
      ecode_in  = ecode_ff;
      skip_nxt  = skip_ext;
      crc_nxt   = crc_ext;
      tmo_nxt   = tmo_ext;
      on_start  = 1'b0;
      to_recv   = 1'b0;
      on_finish = 1'b0;
      tload     = 1'b0;
      tval      = '0;
      found     = 1'b0;
      case (evt.kind)
         KIND_RESPONSE: begin
            if (evt.crc_bad) begin
               eslot_in = act_ff;
               ecode_in = ERR_CRC;
               crc_nxt  = crc_ext | cur_bit;
            end else begin
               crc_nxt   = crc_ext & ~cur_bit;
               tmo_nxt   = tmo_ext & ~cur_bit;
               on_finish = 1'b1;
            end
            skip_nxt = skip_ext | cur_bit;
            state_in = ST_PAUSE;
            tload    = 1'b1;
            tval     = cfg.pause_ticks;
         end
         KIND_TX_DONE: begin
            if ((cfg.receive_mask & cur_bit) != '0) begin
               to_recv  = 1'b1;
               state_in = ST_RECEIVE;
               tload    = 1'b1;
               tval     = cfg.timeout_ticks;
            end else begin
               skip_nxt = skip_ext | cur_bit;
               state_in = ST_PAUSE;
               tload    = 1'b1;
               tval     = cfg.pause_ticks;
            end
         end
         KIND_TIMER: begin
            if (state_ff == ST_PAUSE) begin
               state_in = ST_SELECT;
            end else if (state_ff == ST_RECEIVE) begin
               eslot_in = act_ff;
               ecode_in = ERR_TIMEOUT;
               tmo_nxt  = tmo_ext | cur_bit;
               skip_nxt = skip_ext | cur_bit;
               state_in = ST_SELECT;
            end
         end
         KIND_POLL: begin
            if (state_ff == ST_SELECT) begin
               for (int i = 0; i < FLAG_W; i++) begin
                  if (!found && (COUNT_W'(i) < list_len) && !skip_ext[i]) begin
                     act_in = SLOT_W'(i);
                     if (cfg.start_mask[i]) begin
                        found    = 1'b1;
                        on_start = 1'b1;
                        state_in = ST_TRANSMIT;
                     end
                  end
               end
               if (!found) begin
                  for (int i = 0; i < FLAG_W; i++) begin
                     if ((COUNT_W'(i) < list_len) && cfg.repeat_mask[i]) begin
                        skip_nxt[i] = 1'b0;
                     end
                  end
               end
            end
         end
         KIND_ACTIVATE: begin
            skip_nxt = skip_ext & ~(MASK_W'(1) << evt.slot_index);
         end
         default: begin
            state_in = state_ff;
         end
      endcase

      res.status             = state_in;
      res.current_slot       = act_in;
      res.last_error_slot    = eslot_in;
      res.last_error_code    = ecode_in;
      res.call_on_start      = on_start;
      res.call_to_receive    = to_recv;
      res.call_on_finish     = on_finish;
      res.timer_load_now     = tload;
      res.timer_value        = tval;
      res.slot_crc_error     = crc_nxt[act_in];
      res.slot_timeout_error = tmo_nxt[act_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SELECT;
         act_ff   <= '0;
         skip_ff  <= '0;
         crc_ff   <= '0;
         tmo_ff   <= '0;
         eslot_ff <= '0;
         ecode_ff <= ERR_NONE;
      end else if (step) begin
         state_ff <= state_in;
         act_ff   <= act_in;
         skip_ff  <= skip_nxt[FLAG_W-1:0];
         crc_ff   <= crc_nxt[FLAG_W-1:0];
         tmo_ff   <= tmo_nxt[FLAG_W-1:0];
         eslot_ff <= eslot_in;
         ecode_ff <= ecode_in;
      end
   end

`ifndef SYNTHESIS
   a_start_enters_transmit: assert property (@(posedge clock) disable iff (reset)
      step && res.call_on_start |=> state_ff == ST_TRANSMIT)
      else $error("poll selection did not enter transmit");

   a_receive_timeout_logged: assert property (@(posedge clock) disable iff (reset)
      step && evt.kind == KIND_TIMER && state_ff == ST_RECEIVE
      |=> ecode_ff == ERR_TIMEOUT && state_ff == ST_SELECT)
      else $error("receive timeout not recorded");

   a_hold_without_step: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(state_ff) && $stable(act_ff) && $stable(skip_ff))
      else $error("scheduler state changed without a transaction");

   a_timer_value_idle: assert property (@(posedge clock) disable iff (reset)
      !res.timer_load_now |-> res.timer_value == '0)
      else $error("timer value driven without a load");
`endif

endmodule

/* design/polling_master_slot_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// polling_master_slot_scheduler_unit: bus master slot scheduler
// Steps the select/transmit/receive/pause sequence of a polling bus master
// over a fixed list of request slots, one event per transaction.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one event (kind, crc_bad, slot_index); rsp_* returns one
//   result for every event: the state after it, current slot, last error,
//   callback strobes, timer load and the current slot's error flags.
//   csr_* writes the six configuration registers; write only while idle.
// Path: an accepted event is held in the input register, and its result is
//   loaded into the result register when the event advances.
// Throughput: one event per cycle unless rsp_stall holds the result; the event
//   step is a single pass of logic between the input register and the result
//   register, with the slot priority encoder as its longest path.
// Reset: synchronous; returns to select with slot 0, clears all slot flags,
//   the error record and the configuration, and empties both registers.
// Stall: a stalled result holds in the result register; one more event waits
//   in the input register, then req_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module polling_master_slot_scheduler_unit #(
   parameter int SLOTS = pmss_pkg::SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [pmss_pkg::KIND_W-1:0]     req_kind,
   input  logic                            req_crc_bad,
   input  logic [pmss_pkg::SLOT_W-1:0]     req_slot_index,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [pmss_pkg::STATE_W-1:0]    rsp_status,
   output logic [pmss_pkg::SLOT_W-1:0]     rsp_current_slot,
   output logic [pmss_pkg::SLOT_W-1:0]     rsp_last_error_slot,
   output logic [pmss_pkg::ERR_W-1:0]      rsp_last_error_code,
   output logic                            rsp_call_on_start,
   output logic                            rsp_call_to_receive,
   output logic                            rsp_call_on_finish,
   output logic                            rsp_timer_load_now,
   output logic [pmss_pkg::TICK_W-1:0]     rsp_timer_value,
   output logic                            rsp_slot_crc_error,
   output logic                            rsp_slot_timeout_error,
   input  logic                            csr_write_enable,
   input  logic [pmss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pmss_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import pmss_pkg::*;

   cfg_type    cfg;
   event_type  evt_ff;
   result_type res;
   result_type rsp_ff;
   logic       in_valid_ff;
   logic       rsp_valid_ff;
   logic       advance;
   logic       req_take;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   pmss_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   pmss_engine #(
      .SLOTS (SLOTS)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .evt   (evt_ff),
      .cfg   (cfg),
      .res   (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         evt_ff.kind       <= req_kind;
         evt_ff.crc_bad    <= req_crc_bad;
         evt_ff.slot_index <= req_slot_index;
      end
      if (advance) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_ff.status;
   assign rsp_current_slot       = rsp_ff.current_slot;
   assign rsp_last_error_slot    = rsp_ff.last_error_slot;
   assign rsp_last_error_code    = rsp_ff.last_error_code;
   assign rsp_call_on_start      = rsp_ff.call_on_start;
   assign rsp_call_to_receive    = rsp_ff.call_to_receive;
   assign rsp_call_on_finish     = rsp_ff.call_on_finish;
   assign rsp_timer_load_now     = rsp_ff.timer_load_now;
   assign rsp_timer_value        = rsp_ff.timer_value;
   assign rsp_slot_crc_error     = rsp_ff.slot_crc_error;
   assign rsp_slot_timeout_error = rsp_ff.slot_timeout_error;

`ifndef SYNTHESIS
   a_stalled_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_ff))
      else $error("stalled result transaction changed");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(evt_ff))
      else $error("pending event transaction overwritten");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("result transaction lost");
`endif

endmodule
